@@ hdl/dsh_pkg.sv @@
// package for the decode-stage hazard and branch unit
// holds opcodes, funct3 codes, the jump kind and the records passed between stages
// no dependencies
package dsh_pkg;

    // opcodes and the zero register index
    localparam logic [6:0] OPC_BRANCH = 7'b1100011;
    localparam logic [6:0] OPC_JAL    = 7'b1101111;
    localparam logic [6:0] OPC_JALR   = 7'b1100111;
    localparam logic [6:0] OPC_OPIMM  = 7'b0010011;
    localparam logic [6:0] OPC_LOAD   = 7'b0000011;
    localparam logic [4:0] REG_ZERO   = 5'h00;

    // branch condition codes
    localparam logic [2:0] F3_BEQ  = 3'd0;
    localparam logic [2:0] F3_BNE  = 3'd1;
    localparam logic [2:0] F3_BLT  = 3'd4;
    localparam logic [2:0] F3_BGE  = 3'd5;
    localparam logic [2:0] F3_BLTU = 3'd6;
    localparam logic [2:0] F3_BGEU = 3'd7;
    localparam logic [2:0] F3_JALR = 3'd0;

    // kind of control transfer found in decode
    typedef enum logic [1:0] {
        KIND_NONE   = 2'd0,
        KIND_BRANCH = 2'd1,
        KIND_JAL    = 2'd2,
        KIND_JALR   = 2'd3
    } t_kind;

    // decoded item, first stage
    typedef struct packed {
        logic        stall;
        logic        bub;
        t_kind       kind;
        logic [2:0]  f3;
        logic [31:0] imm;
        logic [31:0] base;
        logic [31:0] rs1;
        logic [31:0] rs2;
        logic [31:0] pc;
        logic [4:0]  rd;
    } t_dec;

    // resolved item, second stage
    typedef struct packed {
        logic        stall;
        logic        bub;
        t_kind       kind;
        logic        cond;
        logic [31:0] sum;
        logic [31:0] link;
        logic [4:0]  rd;
    } t_res;

endpackage

@@ hdl/dsh_in_if.sv @@
// input channel of the decode-stage hazard and branch unit
// valid/ready handshake with the decode-stage fields; no dependencies
interface dsh_in_if;
    logic               valid;
    logic               ready;
    logic [31:0]        instruction;
    logic [31:0]        pc;
    logic               fetch_bubble;
    logic signed [31:0] rs1_value;
    logic signed [31:0] rs2_value;
    logic               ex_writes;
    logic [4:0]         ex_dest;
    logic               mem_writes;
    logic [4:0]         mem_dest;
    logic               wb_writes;
    logic [4:0]         wb_dest;

    modport source (
        output valid, instruction, pc, fetch_bubble, rs1_value, rs2_value,
               ex_writes, ex_dest, mem_writes, mem_dest, wb_writes, wb_dest,
        input  ready
    );
    modport sink (
        input  valid, instruction, pc, fetch_bubble, rs1_value, rs2_value,
               ex_writes, ex_dest, mem_writes, mem_dest, wb_writes, wb_dest,
        output ready
    );
endinterface

@@ hdl/dsh_out_if.sv @@
// output channel of the decode-stage hazard and branch unit
// valid/ready handshake with the result fields; no dependencies
interface dsh_out_if;
    logic        valid;
    logic        ready;
    logic        stall_res;
    logic        bubble;
    logic        branch_taken;
    logic [31:0] branch_target;
    logic        link_write;
    logic [4:0]  link_dest;
    logic [31:0] link_value;

    modport source (
        output valid, stall_res, bubble, branch_taken, branch_target,
               link_write, link_dest, link_value,
        input  ready
    );
    modport sink (
        input  valid, stall_res, bubble, branch_taken, branch_target,
               link_write, link_dest, link_value,
        output ready
    );
endinterface

@@ hdl/dsh_resolve.sv @@
// second pipeline stage: branch compare, target add and return address add
// depends on dsh_pkg
module dsh_resolve (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  dsh_pkg::t_dec i_dec,
    output logic          o_valid,
    output dsh_pkg::t_res o_res
);
    import dsh_pkg::*;

    logic r_valid;
    t_res r_res;
    t_res n_res;
    logic w_eq;
    logic w_lt;
    logic w_ltu;

    // comparisons on the two source values
    assign w_eq  = (i_dec.rs1 == i_dec.rs2);
    assign w_ltu = (i_dec.rs1 < i_dec.rs2);
    assign w_lt  = ($signed(i_dec.rs1) < $signed(i_dec.rs2));

    // branch condition and the two adders
    always_comb begin
        n_res       = '0;
        n_res.stall = i_dec.stall;
        n_res.bub   = i_dec.bub;
        n_res.kind  = i_dec.kind;
        n_res.rd    = i_dec.rd;
        n_res.sum   = i_dec.base + i_dec.imm;
        n_res.link  = i_dec.pc + 32'd4;
        case (i_dec.f3)
            F3_BEQ:  n_res.cond = w_eq;
            F3_BNE:  n_res.cond = !w_eq;
            F3_BLT:  n_res.cond = w_lt;
            F3_BGE:  n_res.cond = !w_lt;
            F3_BLTU: n_res.cond = w_ltu;
            F3_BGEU: n_res.cond = !w_ltu;
            default: n_res.cond = 1'b0;
        endcase
    end

    // stage valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    // stage payload
    always_ff @(posedge i_clk) begin
        if (i_en && i_valid) begin
            r_res <= n_res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

@@ hdl/decode_stage_hazard_and_branch_unit.sv @@
// top level of the decode-stage hazard and branch unit
// depends on dsh_pkg, dsh_in_if, dsh_out_if and dsh_resolve
//
// Usage:
//   i_in carries one decode-stage snapshot per transfer: instruction, pc,
//   fetch bubble flag, both source values and the write enable and
//   destination of the execute, memory and writeback stages.
//   o_out carries one result per input transfer: stall/bubble flags, the
//   taken flag with its redirect target and the link register write.
//   Three register stages: decode and hazard check, compare and adders,
//   result select into the output register. One transfer is taken every
//   cycle while the stage chain can advance.
//   The rate is set by the stage chain: each stage moves when it is empty
//   or the stage after it moves, so a stalled receiver fills the three
//   stages and then drops i_in.ready; nothing is lost or repeated.
//   Reset (i_rst_n low, synchronous) empties all stages; results come back
//   in input order.
module decode_stage_hazard_and_branch_unit (
    input  logic i_clk,
    input  logic i_rst_n,
    dsh_in_if.sink    i_in,
    dsh_out_if.source o_out
);
    import dsh_pkg::*;

    // stage 1: decode and hazard check
    logic        r1_valid;
    t_dec        r1_dec;
    t_dec        n1_dec;
    logic [6:0]  w_opc;
    logic [2:0]  w_f3;
    logic [4:0]  w_s1;
    logic [4:0]  w_s2;
    logic        w_hazard;
    logic [31:0] w_ins;

    // stage 2 outputs
    logic        w2_valid;
    t_res        w2_res;

    // stage 3: output register
    logic        r3_valid;
    logic        r3_stall;
    logic        r3_bub;
    logic        r3_taken;
    logic [31:0] r3_target;
    logic        r3_lw;
    logic [4:0]  r3_ld;
    logic [31:0] r3_lv;
    logic        n3_taken;
    logic [31:0] n3_target;
    logic        n3_lw;

    logic        w_adv1;
    logic        w_adv2;
    logic        w_adv3;

    // one stage conflict: writing, nonzero destination matching a used source
    function automatic logic stage_hit(input logic wr, input logic [4:0] dst,
                                       input logic [4:0] s1, input logic [4:0] s2);
        stage_hit = wr && (dst != REG_ZERO) &&
                    (((s1 != REG_ZERO) && (dst == s1)) ||
                     ((s2 != REG_ZERO) && (dst == s2)));
    endfunction

    // stage advance chain
    assign w_adv3     = !r3_valid || o_out.ready;
    assign w_adv2     = !w2_valid || w_adv3;
    assign w_adv1     = !r1_valid || w_adv2;
    assign i_in.ready = w_adv1;

    // instruction fields
    assign w_ins = i_in.instruction;
    assign w_opc = w_ins[6:0];
    assign w_f3  = w_ins[14:12];
    assign w_s1  = w_ins[19:15];
    assign w_s2  = ((w_opc == OPC_OPIMM) || (w_opc == OPC_LOAD) || (w_opc == OPC_JALR))
                   ? REG_ZERO : w_ins[24:20];

    assign w_hazard = stage_hit(i_in.ex_writes,  i_in.ex_dest,  w_s1, w_s2) ||
                      stage_hit(i_in.mem_writes, i_in.mem_dest, w_s1, w_s2) ||
                      stage_hit(i_in.wb_writes,  i_in.wb_dest,  w_s1, w_s2);

    // decode: kind, immediate and adder base
    always_comb begin
        n1_dec       = '0;
        n1_dec.f3    = w_f3;
        n1_dec.rs1   = i_in.rs1_value;
        n1_dec.rs2   = i_in.rs2_value;
        n1_dec.pc    = i_in.pc;
        n1_dec.rd    = w_ins[11:7];
        n1_dec.base  = i_in.pc;
        n1_dec.kind  = KIND_NONE;
        if (i_in.fetch_bubble) begin
            n1_dec.bub = 1'b1;
        end else if (w_hazard) begin
            n1_dec.stall = 1'b1;
            n1_dec.bub   = 1'b1;
        end else begin
            case (w_opc)
                OPC_BRANCH: begin
                    n1_dec.kind = KIND_BRANCH;
                    n1_dec.imm  = {{20{w_ins[31]}}, w_ins[7], w_ins[30:25],
                                   w_ins[11:8], 1'b0};
                end
                OPC_JAL: begin
                    n1_dec.kind = KIND_JAL;
                    n1_dec.imm  = {{12{w_ins[31]}}, w_ins[19:12], w_ins[20],
                                   w_ins[30:21], 1'b0};
                end
                OPC_JALR: begin
                    if (w_f3 == F3_JALR) begin
                        n1_dec.kind = KIND_JALR;
                    end
                    n1_dec.imm  = {{20{w_ins[31]}}, w_ins[31:20]};
                    n1_dec.base = i_in.rs1_value;
                end
                default: n1_dec.kind = KIND_NONE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (w_adv1) begin
            r1_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv1 && i_in.valid) begin
            r1_dec <= n1_dec;
        end
    end

    // stage 2: compare and adders
    dsh_resolve u_resolve (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv2),
        .i_valid (r1_valid),
        .i_dec   (r1_dec),
        .o_valid (w2_valid),
        .o_res   (w2_res)
    );

    // stage 3: result select
    always_comb begin
        case (w2_res.kind)
            KIND_BRANCH: n3_taken = w2_res.cond;
            KIND_JAL:    n3_taken = 1'b1;
            KIND_JALR:   n3_taken = 1'b1;
            default:     n3_taken = 1'b0;
        endcase
        n3_lw = ((w2_res.kind == KIND_JAL) || (w2_res.kind == KIND_JALR)) &&
                (w2_res.rd != REG_ZERO);
        if (!n3_taken) begin
            n3_target = '0;
        end else if (w2_res.kind == KIND_JALR) begin
            n3_target = {w2_res.sum[31:1], 1'b0};
        end else begin
            n3_target = w2_res.sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_valid <= 1'b0;
        end else if (w_adv3) begin
            r3_valid <= w2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv3 && w2_valid) begin
            r3_stall  <= w2_res.stall;
            r3_bub    <= w2_res.bub;
            r3_taken  <= n3_taken;
            r3_target <= n3_target;
            r3_lw     <= n3_lw;
            r3_ld     <= n3_lw ? w2_res.rd : REG_ZERO;
            r3_lv     <= n3_lw ? w2_res.link : 32'd0;
        end
    end

    // output channel
    assign o_out.valid         = r3_valid;
    assign o_out.stall_res     = r3_stall;
    assign o_out.bubble        = r3_bub;
    assign o_out.branch_taken  = r3_taken;
    assign o_out.branch_target = r3_target;
    assign o_out.link_write    = r3_lw;
    assign o_out.link_dest     = r3_ld;
    assign o_out.link_value    = r3_lv;

    // a hazard always comes with a bubble
    a_stall_bubble: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.stall_res) |-> o_out.bubble)
        else $error("stall without bubble");

    // a bubbled item never redirects fetch
    a_bubble_no_branch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.bubble) |-> (!o_out.branch_taken && !o_out.link_write))
        else $error("bubble with branch or link");

    // a link write only comes from a taken jump
    a_link_taken: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.link_write) |-> o_out.branch_taken)
        else $error("link write without taken jump");

    // a held middle stage keeps its item while the output is stalled
    a_stage_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w2_valid && !w_adv3) |=> w2_valid)
        else $error("stage two lost an item under stall");

endmodule

@@ sim/dsh_decode_checker.sv @@
// result checker for the decode-stage hazard and branch unit
// predicts one result per input transfer and compares it with the output transfers
// depends on dsh_pkg, dsh_in_if and dsh_out_if
module dsh_decode_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    dsh_in_if    i_in_mon,
    dsh_out_if   i_out_mon,
    output int   o_fail_count,
    output int   o_pending,
    output int   o_results,
    output int   o_stalls,
    output int   o_redirects,
    output int   o_links
);
    import dsh_pkg::*;

    // one predicted decode outcome
    typedef struct packed {
        logic        stall;
        logic        bubble;
        logic        taken;
        logic [31:0] target;
        logic        lwrite;
        logic [4:0]  ldest;
        logic [31:0] lvalue;
    } t_outcome;

    t_outcome pending_outcomes[$];

    // a later stage writes a register that decode reads
    function automatic logic stage_hits(logic wr, logic [4:0] dst, logic [4:0] s1,
                                        logic [4:0] s2);
        return wr && dst != REG_ZERO && (dst == s1 || dst == s2);
    endfunction

    function automatic t_outcome predict_outcome(
        logic [31:0] ins, logic [31:0] pc, logic fb, logic [31:0] a, logic [31:0] b,
        logic exw, logic [4:0] exd, logic mw, logic [4:0] md, logic ww, logic [4:0] wd);
        t_outcome    r;
        logic [6:0]  opc;
        logic [2:0]  f3;
        logic [4:0]  s1, s2, rd;
        logic [31:0] imm_b, imm_j, imm_i, jalr_sum;
        logic        cond;
        opc = ins[6:0];
        f3  = ins[14:12];
        s1  = ins[19:15];
        s2  = ins[24:20];
        rd  = ins[11:7];
        imm_b = {{19{ins[31]}}, ins[31], ins[7], ins[30:25], ins[11:8], 1'b0};
        imm_j = {{11{ins[31]}}, ins[31], ins[19:12], ins[20], ins[30:21], 1'b0};
        imm_i = {{20{ins[31]}}, ins[31:20]};
        jalr_sum = a + imm_i;
        cond = 1'b0;
        r = '0;
        // formats without an rs2 field
        if (opc == OPC_OPIMM || opc == OPC_LOAD || opc == OPC_JALR)
            s2 = REG_ZERO;
        if (fb) begin
            r.bubble = 1'b1;
        end else if (stage_hits(exw, exd, s1, s2) || stage_hits(mw, md, s1, s2) ||
                     stage_hits(ww, wd, s1, s2)) begin
            r.stall  = 1'b1;
            r.bubble = 1'b1;
        end else if (opc == OPC_BRANCH) begin
            case (f3)
                F3_BEQ:  cond = (a == b);
                F3_BNE:  cond = (a != b);
                F3_BLT:  cond = ($signed(a) < $signed(b));
                F3_BGE:  cond = ($signed(a) >= $signed(b));
                F3_BLTU: cond = (a < b);
                F3_BGEU: cond = (a >= b);
                default: cond = 1'b0;
            endcase
            if (cond) begin
                r.taken  = 1'b1;
                r.target = pc + imm_b;
            end
        end else if (opc == OPC_JAL || (opc == OPC_JALR && f3 == F3_JALR)) begin
            r.taken  = 1'b1;
            r.target = (opc == OPC_JAL) ? pc + imm_j : {jalr_sum[31:1], 1'b0};
            if (rd != REG_ZERO) begin
                r.lwrite = 1'b1;
                r.ldest  = rd;
                r.lvalue = pc + 32'd4;
            end
        end
        return r;
    endfunction

    task automatic compare_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
            o_fail_count++;
        end
    endtask

    // watch both channels; outputs are checked before the new prediction is queued
    always @(posedge i_clk) begin
        t_outcome want;
        if (!i_rst_n) begin
            pending_outcomes.delete();
            o_pending <= 0;
        end else begin
            if (i_out_mon.valid && i_out_mon.ready) begin
                if (pending_outcomes.size() == 0) begin
                    $display("%0t: result transfer with no prediction pending", $time);
                    o_fail_count++;
                end else begin
                    want = pending_outcomes.pop_front();
                    compare_field("stall_res", want.stall, i_out_mon.stall_res);
                    compare_field("bubble", want.bubble, i_out_mon.bubble);
                    compare_field("branch_taken", want.taken, i_out_mon.branch_taken);
                    compare_field("branch_target", want.target, i_out_mon.branch_target);
                    compare_field("link_write", want.lwrite, i_out_mon.link_write);
                    compare_field("link_dest", want.ldest, i_out_mon.link_dest);
                    compare_field("link_value", want.lvalue, i_out_mon.link_value);
                    o_results++;
                    if (want.stall)
                        o_stalls++;
                    if (want.taken)
                        o_redirects++;
                    if (want.lwrite)
                        o_links++;
                end
            end
            if (i_in_mon.valid && i_in_mon.ready) begin
                pending_outcomes.push_back(predict_outcome(
                    i_in_mon.instruction, i_in_mon.pc, i_in_mon.fetch_bubble,
                    i_in_mon.rs1_value, i_in_mon.rs2_value,
                    i_in_mon.ex_writes, i_in_mon.ex_dest, i_in_mon.mem_writes,
                    i_in_mon.mem_dest, i_in_mon.wb_writes, i_in_mon.wb_dest));
            end
            o_pending <= pending_outcomes.size();
        end
    end

endmodule

@@ sim/decode_stage_hazard_and_branch_unit_tb.sv @@
// testbench top for the decode-stage hazard and branch unit
// drives decode snapshots and the result ready, then reports the verdict
// depends on dsh_pkg, dsh_in_if, dsh_out_if, the block and dsh_decode_checker
module decode_stage_hazard_and_branch_unit_tb;
    import dsh_pkg::*;

    localparam logic [6:0] OPC_LUI     = 7'b0110111;
    localparam logic [6:0] OPC_AUIPC   = 7'b0010111;
    localparam logic [2:0] F3_RSVD_A   = 3'd2;
    localparam logic [2:0] F3_RSVD_B   = 3'd3;
    localparam logic [2:0] F3_JALR_BAD = 3'd1;
    localparam logic [2:0] F3_ADDI     = 3'd0;
    localparam logic [2:0] F3_LW       = 3'd2;
    localparam int RANDOM_ITEMS = 950;

    // one decode-stage snapshot
    typedef struct packed {
        logic [31:0]        instruction;
        logic [31:0]        pc;
        logic               fetch_bubble;
        logic signed [31:0] rs1_value;
        logic signed [31:0] rs2_value;
        logic               ex_writes;
        logic [4:0]         ex_dest;
        logic               mem_writes;
        logic [4:0]         mem_dest;
        logic               wb_writes;
        logic [4:0]         wb_dest;
    } t_snapshot;

    logic i_clk;
    logic i_rst_n;
    logic src_idle_on;
    logic sink_idle_on;
    int   sink_hold;
    int   sent_count;
    int   fail_count, pending_count, results_seen, stall_seen, redirect_seen, link_seen;

    dsh_in_if  in_ch ();
    dsh_out_if out_ch ();

    decode_stage_hazard_and_branch_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    dsh_decode_checker result_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_mon     (in_ch),
        .i_out_mon    (out_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending_count),
        .o_results    (results_seen),
        .o_stalls     (stall_seen),
        .o_redirects  (redirect_seen),
        .o_links      (link_seen)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        #2000000;
        $display("tb: failure");
        $finish;
    end

    // receiver stalls in bursts of random length while sink idling is on
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            sink_hold    <= 0;
            out_ch.ready <= 1'b0;
        end else if (sink_hold != 0) begin
            sink_hold    <= sink_hold - 1;
            out_ch.ready <= 1'b0;
        end else if (sink_idle_on && $urandom_range(0, 5) == 0) begin
            sink_hold    <= $urandom_range(0, 6);
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= 1'b1;
        end
    end

    function automatic logic [31:0] enc_branch(logic [2:0] f3, logic [4:0] rs1,
                                               logic [4:0] rs2, logic [12:0] off);
        return {off[12], off[10:5], rs2, rs1, f3, off[4:1], off[11], OPC_BRANCH};
    endfunction

    function automatic logic [31:0] enc_jal(logic [4:0] rd, logic [20:0] off);
        return {off[20], off[10:1], off[11], off[19:12], rd, OPC_JAL};
    endfunction

    function automatic logic [31:0] enc_itype(logic [6:0] opc, logic [2:0] f3,
                                              logic [4:0] rd, logic [4:0] rs1,
                                              logic [11:0] imm);
        return {imm, rs1, f3, rd, opc};
    endfunction

    // snapshot with no later-stage writes and zero operands
    function automatic t_snapshot plain_snapshot(logic [31:0] ins);
        t_snapshot s;
        s = '0;
        s.instruction = ins;
        s.pc = 32'h0000_1000;
        return s;
    endfunction

    // operand values lean toward the signed and unsigned boundaries
    function automatic logic [31:0] pick_operand();
        case ($urandom_range(0, 7))
            0:       return 32'h0000_0000;
            1:       return 32'h7fff_ffff;
            2:       return 32'h8000_0000;
            3:       return 32'hffff_ffff;
            4:       return $urandom_range(0, 15);
            default: return $urandom();
        endcase
    endfunction

    function automatic t_snapshot random_snapshot();
        t_snapshot   s;
        logic [31:0] w;
        logic [4:0]  s1, s2;
        logic        wr [3];
        logic [4:0]  dst [3];
        int          cls, mode, k;
        w = $urandom();
        cls = $urandom_range(0, 99);
        // mostly control transfers and formats that drop rs2, some lui/auipc; the rest raw words
        if (cls < 35) begin
            w[6:0] = OPC_BRANCH;
        end else if (cls < 45) begin
            w[6:0] = OPC_JAL;
        end else if (cls < 57) begin
            w[6:0] = OPC_JALR;
            if ($urandom_range(0, 6) != 0)
                w[14:12] = F3_JALR;
        end else if (cls < 67) begin
            w[6:0] = OPC_OPIMM;
        end else if (cls < 75) begin
            w[6:0] = OPC_LOAD;
        end else if (cls < 80) begin
            w[6:0] = $urandom_range(0, 1) ? OPC_LUI : OPC_AUIPC;
        end
        s.instruction  = w;
        s.pc           = $urandom();
        s.fetch_bubble = ($urandom_range(0, 11) == 0);
        s.rs1_value    = pick_operand();
        case ($urandom_range(0, 9))
            0, 1, 2: s.rs2_value = s.rs1_value;
            3:       s.rs2_value = s.rs1_value + 1;
            4:       s.rs2_value = s.rs1_value - 1;
            default: s.rs2_value = pick_operand();
        endcase
        s1 = w[19:15];
        s2 = w[24:20];
        // later stages: clean, one forced match, or anything
        mode = $urandom_range(0, 9);
        for (k = 0; k < 3; k++) begin
            wr[k] = $urandom_range(0, 1);
            if (mode < 6) begin
                do
                    dst[k] = $urandom_range(0, 31);
                while (dst[k] != REG_ZERO && (dst[k] == s1 || dst[k] == s2));
            end else begin
                dst[k] = $urandom_range(0, 31);
            end
        end
        if (mode >= 6 && mode < 9) begin
            k = $urandom_range(0, 2);
            wr[k]  = 1'b1;
            dst[k] = $urandom_range(0, 1) ? s1 : s2;
        end
        s.ex_writes  = wr[0];
        s.ex_dest    = dst[0];
        s.mem_writes = wr[1];
        s.mem_dest   = dst[1];
        s.wb_writes  = wr[2];
        s.wb_dest    = dst[2];
        return s;
    endfunction

    // one transfer, with an optional sender gap in front
    task automatic send_snapshot(input t_snapshot s);
        int gap;
        if (src_idle_on && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 7);
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid        <= 1'b1;
        in_ch.instruction  <= s.instruction;
        in_ch.pc           <= s.pc;
        in_ch.fetch_bubble <= s.fetch_bubble;
        in_ch.rs1_value    <= s.rs1_value;
        in_ch.rs2_value    <= s.rs2_value;
        in_ch.ex_writes    <= s.ex_writes;
        in_ch.ex_dest      <= s.ex_dest;
        in_ch.mem_writes   <= s.mem_writes;
        in_ch.mem_dest     <= s.mem_dest;
        in_ch.wb_writes    <= s.wb_writes;
        in_ch.wb_dest      <= s.wb_dest;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        sent_count++;
    endtask

    // stop sending until every predicted result has come back
    task automatic drain_results();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_count != 0) @(posedge i_clk);
    endtask

    // stimulus
    initial begin
        t_snapshot snap;
        int        n, directed_count;
        i_rst_n            <= 1'b0;
        in_ch.valid        <= 1'b0;
        in_ch.instruction  <= '0;
        in_ch.pc           <= '0;
        in_ch.fetch_bubble <= 1'b0;
        in_ch.rs1_value    <= '0;
        in_ch.rs2_value    <= '0;
        in_ch.ex_writes    <= 1'b0;
        in_ch.ex_dest      <= '0;
        in_ch.mem_writes   <= 1'b0;
        in_ch.mem_dest     <= '0;
        in_ch.wb_writes    <= 1'b0;
        in_ch.wb_dest      <= '0;
        sink_idle_on       <= 1'b0;
        src_idle_on = 1'b0;
        sent_count  = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // fetch bubble outranks a hazard
        snap = plain_snapshot(enc_branch(F3_BEQ, 5'd1, 5'd2, 13'h0008));
        snap.fetch_bubble = 1'b1;
        snap.ex_writes = 1'b1;
        snap.ex_dest = 5'd1;
        send_snapshot(snap);
        // hazard on rs1 from execute
        snap = plain_snapshot(enc_itype(OPC_OPIMM, F3_ADDI, 5'd3, 5'd7, 12'h005));
        snap.ex_writes = 1'b1;
        snap.ex_dest = 5'd7;
        send_snapshot(snap);
        // hazard on rs2 from memory
        snap = plain_snapshot(enc_branch(F3_BNE, 5'd4, 5'd9, 13'h0010));
        snap.mem_writes = 1'b1;
        snap.mem_dest = 5'd9;
        send_snapshot(snap);
        // hazard on rs1 from writeback
        snap = plain_snapshot(enc_itype(OPC_JALR, F3_JALR, 5'd1, 5'd12, 12'h000));
        snap.wb_writes = 1'b1;
        snap.wb_dest = 5'd12;
        send_snapshot(snap);
        // x0 never conflicts
        snap = plain_snapshot(enc_branch(F3_BEQ, 5'd0, 5'd0, 13'h0010));
        snap.ex_writes = 1'b1;
        snap.mem_writes = 1'b1;
        snap.wb_writes = 1'b1;
        send_snapshot(snap);
        // matching destination without a write enable
        snap = plain_snapshot(enc_branch(F3_BNE, 5'd6, 5'd6, 13'h0020));
        snap.ex_dest = 5'd6;
        snap.mem_dest = 5'd6;
        snap.wb_dest = 5'd6;
        snap.rs1_value = 32'sd1;
        snap.rs2_value = 32'sd2;
        send_snapshot(snap);
        // signed less-than, backward offset
        snap = plain_snapshot(enc_branch(F3_BLT, 5'd1, 5'd2, 13'h1ff0));
        snap.rs1_value = -32'sd1;
        snap.rs2_value = 32'sd1;
        send_snapshot(snap);
        // signed greater-or-equal at the boundary, not taken then taken
        snap = plain_snapshot(enc_branch(F3_BGE, 5'd1, 5'd2, 13'h0ffe));
        snap.rs1_value = 32'h8000_0000;
        snap.rs2_value = 32'h7fff_ffff;
        send_snapshot(snap);
        snap.rs1_value = 32'sd5;
        snap.rs2_value = 32'sd5;
        send_snapshot(snap);
        // unsigned compares where signed order differs
        snap = plain_snapshot(enc_branch(F3_BLTU, 5'd1, 5'd2, 13'h1000));
        snap.rs1_value = 32'sd1;
        snap.rs2_value = 32'hffff_ffff;
        send_snapshot(snap);
        snap.rs1_value = 32'hffff_ffff;
        snap.rs2_value = 32'sd0;
        send_snapshot(snap);
        snap = plain_snapshot(enc_branch(F3_BGEU, 5'd1, 5'd2, 13'h0004));
        snap.rs1_value = 32'h8000_0000;
        snap.rs2_value = 32'h7fff_ffff;
        send_snapshot(snap);
        // reserved branch conditions never take
        snap = plain_snapshot(enc_branch(F3_RSVD_A, 5'd1, 5'd2, 13'h0040));
        send_snapshot(snap);
        snap = plain_snapshot(enc_branch(F3_RSVD_B, 5'd1, 5'd2, 13'h0040));
        send_snapshot(snap);
        // jal: most negative offset, largest offset with rd x0, link wrap
        snap = plain_snapshot(enc_jal(5'd1, 21'h10_0000));
        snap.pc = 32'h0000_0000;
        send_snapshot(snap);
        snap = plain_snapshot(enc_jal(5'd0, 21'h0f_fffe));
        snap.pc = 32'hffff_fffc;
        send_snapshot(snap);
        snap = plain_snapshot(enc_jal(5'd31, 21'h00_0008));
        snap.pc = 32'hffff_fffc;
        send_snapshot(snap);
        // jalr with an odd base and the largest positive immediate
        snap = plain_snapshot(enc_itype(OPC_JALR, F3_JALR, 5'd5, 5'd3, 12'h7ff));
        snap.rs1_value = 32'h0000_1001;
        send_snapshot(snap);
        // jalr with a nonzero funct3 is not a jump
        snap = plain_snapshot(enc_itype(OPC_JALR, F3_JALR_BAD, 5'd5, 5'd3, 12'h010));
        send_snapshot(snap);
        // rs2 field ignored for op-imm, load and jalr
        snap = plain_snapshot(enc_itype(OPC_OPIMM, F3_ADDI, 5'd2, 5'd3, 12'h009));
        snap.ex_writes = 1'b1;
        snap.ex_dest = 5'd9;
        send_snapshot(snap);
        snap = plain_snapshot(enc_itype(OPC_LOAD, F3_LW, 5'd2, 5'd3, 12'h009));
        snap.mem_writes = 1'b1;
        snap.mem_dest = 5'd9;
        send_snapshot(snap);
        snap = plain_snapshot(enc_itype(OPC_JALR, F3_JALR, 5'd2, 5'd3, 12'h009));
        snap.wb_writes = 1'b1;
        snap.wb_dest = 5'd9;
        send_snapshot(snap);
        // lui and auipc still compare their source fields
        snap = plain_snapshot(enc_itype(OPC_LUI, 3'd0, 5'd2, 5'd11, 12'h000));
        snap.ex_writes = 1'b1;
        snap.ex_dest = 5'd11;
        send_snapshot(snap);
        snap = plain_snapshot(enc_itype(OPC_AUIPC, 3'd0, 5'd2, 5'd0, 12'h00d));
        snap.mem_writes = 1'b1;
        snap.mem_dest = 5'd13;
        send_snapshot(snap);
        // all ones and all zeros
        snap = '1;
        snap.rs1_value = 32'h7fff_ffff;
        snap.rs2_value = 32'h8000_0000;
        send_snapshot(snap);
        snap = '0;
        send_snapshot(snap);
        directed_count = sent_count;

        // random part in phases of idling: both sides, receiver only,
        // sender only after a full drain, then none
        for (n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == 0) begin
                src_idle_on = 1'b1;
                sink_idle_on <= 1'b1;
            end else if (n == 320) begin
                src_idle_on = 1'b0;
            end else if (n == 480) begin
                drain_results();
                src_idle_on = 1'b1;
                sink_idle_on <= 1'b0;
            end else if (n == 700) begin
                src_idle_on = 1'b0;
            end
            send_snapshot(random_snapshot());
        end

        drain_results();
        repeat (10) @(posedge i_clk);
        $display("summary: %0d directed and %0d random snapshots, idling in bursts on both sides",
                 directed_count, sent_count - directed_count);
        $display("summary: %0d results checked, %0d stalls, %0d redirects, %0d link writes",
                 results_seen, stall_seen, redirect_seen, link_seen);
        if (fail_count == 0 && pending_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

@@ decode_stage_hazard_and_branch_unit.f @@
hdl/dsh_pkg.sv
hdl/dsh_in_if.sv
hdl/dsh_out_if.sv
hdl/dsh_resolve.sv
hdl/decode_stage_hazard_and_branch_unit.sv
sim/dsh_decode_checker.sv
sim/decode_stage_hazard_and_branch_unit_tb.sv
